// ----- hdl/gtr_pkg.sv -----
`timescale 1ns / 1ps

package gtr_pkg;

  localparam logic [7:0] GTR_FIRST_CODE = 8'h20;
  localparam logic [7:0] GTR_LAST_CODE  = 8'h7E;
  localparam logic [7:0] GTR_NEWLINE    = 8'h0A;
  localparam int unsigned GTR_CELL_ADV  = 6;
  localparam int unsigned GTR_LINE_ADV  = 8;
  localparam int unsigned GTR_CELL_W    = 6;
  localparam int unsigned GTR_CELL_H    = 8;
  localparam int unsigned GTR_GLYPH_CNT = 'h5F;
  localparam int unsigned GTR_FIFO_DEPTH = 2;

  localparam logic [15:0] GTR_WIDTH_RST  = 16'd240;
  localparam logic [15:0] GTR_HEIGHT_RST = 16'd240;

  localparam logic GTR_REG_WIDTH  = 1'b0;
  localparam logic GTR_REG_HEIGHT = 1'b1;

  typedef logic [0:4][7:0] gtr_glyph_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] fg;
    logic [15:0] bg;
    gtr_glyph_t  glyph;
    logic [2:0]  ncols;
    logic [3:0]  nrows;
  } gtr_cell_t;

  function automatic gtr_glyph_t gtr_glyph(input logic [6:0] idx);
    gtr_glyph_t g;
    case (idx)
      7'd0:  g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      7'd1:  g = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
      7'd2:  g = {8'h00, 8'h07, 8'h00, 8'h07, 8'h00};
      7'd3:  g = {8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14};
      7'd4:  g = {8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12};
      7'd5:  g = {8'h23, 8'h13, 8'h08, 8'h64, 8'h62};
      7'd6:  g = {8'h36, 8'h49, 8'h55, 8'h22, 8'h50};
      7'd7:  g = {8'h00, 8'h05, 8'h03, 8'h00, 8'h00};
      7'd8:  g = {8'h00, 8'h1C, 8'h22, 8'h41, 8'h00};
      7'd9:  g = {8'h00, 8'h41, 8'h22, 8'h1C, 8'h00};
      7'd10: g = {8'h08, 8'h2A, 8'h1C, 8'h2A, 8'h08};
      7'd11: g = {8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
      7'd12: g = {8'h00, 8'h50, 8'h30, 8'h00, 8'h00};
      7'd13: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
      7'd14: g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
      7'd15: g = {8'h20, 8'h10, 8'h08, 8'h04, 8'h02};
      7'd16: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      7'd17: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      7'd18: g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      7'd19: g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      7'd20: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      7'd21: g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      7'd22: g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      7'd23: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      7'd24: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      7'd25: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      7'd26: g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
      7'd27: g = {8'h00, 8'h56, 8'h36, 8'h00, 8'h00};
      7'd28: g = {8'h00, 8'h08, 8'h14, 8'h22, 8'h41};
      7'd29: g = {8'h14, 8'h14, 8'h14, 8'h14, 8'h14};
      7'd30: g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h00};
      7'd31: g = {8'h02, 8'h01, 8'h51, 8'h09, 8'h06};
      7'd32: g = {8'h32, 8'h49, 8'h79, 8'h41, 8'h3E};
      7'd33: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
      7'd34: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
      7'd35: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
      7'd36: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
      7'd37: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
      7'd38: g = {8'h7F, 8'h09, 8'h09, 8'h01, 8'h01};
      7'd39: g = {8'h3E, 8'h41, 8'h41, 8'h51, 8'h32};
      7'd40: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
      7'd41: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
      7'd42: g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
      7'd43: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
      7'd44: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
      7'd45: g = {8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F};
      7'd46: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
      7'd47: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
      7'd48: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
      7'd49: g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
      7'd50: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
      7'd51: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      7'd52: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
      7'd53: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
      7'd54: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
      7'd55: g = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
      7'd56: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      7'd57: g = {8'h03, 8'h04, 8'h78, 8'h04, 8'h03};
      7'd58: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
      7'd59: g = {8'h00, 8'h00, 8'h7F, 8'h41, 8'h41};
      7'd60: g = {8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
      7'd61: g = {8'h41, 8'h41, 8'h7F, 8'h00, 8'h00};
      7'd62: g = {8'h04, 8'h02, 8'h01, 8'h02, 8'h04};
      7'd63: g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h40};
      7'd64: g = {8'h00, 8'h01, 8'h02, 8'h04, 8'h00};
      7'd65: g = {8'h20, 8'h54, 8'h54, 8'h54, 8'h78};
      7'd66: g = {8'h7F, 8'h48, 8'h44, 8'h44, 8'h38};
      7'd67: g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h20};
      7'd68: g = {8'h38, 8'h44, 8'h44, 8'h48, 8'h7F};
      7'd69: g = {8'h38, 8'h54, 8'h54, 8'h54, 8'h18};
      7'd70: g = {8'h08, 8'h7E, 8'h09, 8'h01, 8'h02};
      7'd71: g = {8'h08, 8'h14, 8'h54, 8'h54, 8'h3C};
      7'd72: g = {8'h7F, 8'h08, 8'h04, 8'h04, 8'h78};
      7'd73: g = {8'h00, 8'h44, 8'h7D, 8'h40, 8'h00};
      7'd74: g = {8'h20, 8'h40, 8'h44, 8'h3D, 8'h00};
      7'd75: g = {8'h00, 8'h7F, 8'h10, 8'h28, 8'h44};
      7'd76: g = {8'h00, 8'h41, 8'h7F, 8'h40, 8'h00};
      7'd77: g = {8'h7C, 8'h04, 8'h18, 8'h04, 8'h78};
      7'd78: g = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h78};
      7'd79: g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
      7'd80: g = {8'h7C, 8'h14, 8'h14, 8'h14, 8'h08};
      7'd81: g = {8'h08, 8'h14, 8'h14, 8'h18, 8'h7C};
      7'd82: g = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h08};
      7'd83: g = {8'h48, 8'h54, 8'h54, 8'h54, 8'h20};
      7'd84: g = {8'h04, 8'h3F, 8'h44, 8'h40, 8'h20};
      7'd85: g = {8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C};
      7'd86: g = {8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C};
      7'd87: g = {8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C};
      7'd88: g = {8'h44, 8'h28, 8'h10, 8'h28, 8'h44};
      7'd89: g = {8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C};
      7'd90: g = {8'h44, 8'h64, 8'h54, 8'h4C, 8'h44};
      7'd91: g = {8'h00, 8'h08, 8'h36, 8'h41, 8'h00};
      7'd92: g = {8'h00, 8'h00, 8'h7F, 8'h00, 8'h00};
      7'd93: g = {8'h00, 8'h41, 8'h36, 8'h08, 8'h00};
      7'd94: g = {8'h10, 8'h08, 8'h08, 8'h10, 8'h08};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ----- hdl/gtr_front.sv -----
`timescale 1ns / 1ps

module gtr_front
  import gtr_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        new_string,
  input  logic [15:0] start_x,
  input  logic [15:0] start_y,
  input  logic [15:0] fg_colour,
  input  logic [15:0] bg_colour,
  input  logic [15:0] screen_width,
  input  logic [15:0] screen_height,
  input  logic        q_ready,
  output logic        q_push,
  output gtr_cell_t   q_cell
);

  localparam int CW = COORD_BITS + 1;
  localparam int WW = (CW > 16) ? CW : 16;
  localparam logic [COORD_BITS-1:0] CMAX = '1;

  logic [COORD_BITS-1:0] col_r, col_nxt;
  logic [COORD_BITS-1:0] row_r, row_nxt;
  logic [COORD_BITS-1:0] ls_r, ls_nxt;

  logic [COORD_BITS-1:0] x_eff, y_eff, ls_eff;
  logic [CW-1:0]         col_sum, row_sum;
  logic [COORD_BITS-1:0] col_sat, row_sat;
  logic [7:0]            code_eff;
  logic [2:0]            ncols;
  logic [3:0]            nrows;
  logic                  is_nl;
  logic                  accept;

  always_comb begin
    x_eff  = new_string ? COORD_BITS'(start_x) : col_r;
    y_eff  = new_string ? COORD_BITS'(start_y) : row_r;
    ls_eff = new_string ? COORD_BITS'(start_x) : ls_r;
    is_nl  = (char_code == GTR_NEWLINE);

    if ((char_code < GTR_FIRST_CODE) || (char_code > GTR_LAST_CODE)) begin
      code_eff = GTR_FIRST_CODE;
    end else begin
      code_eff = char_code;
    end

    ncols = '0;
    for (int i = 0; i < GTR_CELL_W; i++) begin
      if ((WW'(x_eff) + WW'(i)) < WW'(screen_width)) begin
        ncols = ncols + 3'd1;
      end
    end
    nrows = '0;
    for (int i = 0; i < GTR_CELL_H; i++) begin
      if ((WW'(y_eff) + WW'(i)) < WW'(screen_height)) begin
        nrows = nrows + 4'd1;
      end
    end

    col_sum = {1'b0, x_eff} + CW'(GTR_CELL_ADV);
    row_sum = {1'b0, y_eff} + CW'(GTR_LINE_ADV);
    col_sat = col_sum[CW-1] ? CMAX : col_sum[COORD_BITS-1:0];
    row_sat = row_sum[CW-1] ? CMAX : row_sum[COORD_BITS-1:0];

    in_ready = q_ready;
    accept   = in_valid && q_ready;
    q_push   = accept && !is_nl && (ncols != 3'd0) && (nrows != 4'd0);

    q_cell.x     = 16'(x_eff);
    q_cell.y     = 16'(y_eff);
    q_cell.fg    = fg_colour;
    q_cell.bg    = bg_colour;
    q_cell.glyph = gtr_glyph(7'(code_eff - GTR_FIRST_CODE));
    q_cell.ncols = ncols;
    q_cell.nrows = nrows;

    col_nxt = col_r;
    row_nxt = row_r;
    ls_nxt  = ls_r;
    if (accept) begin
      ls_nxt = ls_eff;
      if (is_nl) begin
        col_nxt = ls_eff;
        row_nxt = row_sat;
      end else begin
        col_nxt = col_sat;
        row_nxt = y_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      ls_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ls_r  <= ls_nxt;
    end
  end

endmodule

// ----- hdl/gtr_fifo.sv -----
`timescale 1ns / 1ps

module gtr_fifo
  import gtr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  gtr_cell_t push_cell,
  output logic      ready,
  input  logic      pop,
  output logic      valid,
  output gtr_cell_t head
);

  localparam int PW = (GTR_FIFO_DEPTH > 1) ? $clog2(GTR_FIFO_DEPTH) : 1;
  localparam int NW = $clog2(GTR_FIFO_DEPTH + 1);

  gtr_cell_t         mem_r [GTR_FIFO_DEPTH];
  logic [PW-1:0]     wr_r, wr_nxt;
  logic [PW-1:0]     rd_r, rd_nxt;
  logic [NW-1:0]     cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(GTR_FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    ready   = (cnt_r != NW'(GTR_FIFO_DEPTH));
    valid   = (cnt_r != '0);
    head    = mem_r[rd_r];
    wr_nxt  = push ? ptr_inc(wr_r) : wr_r;
    rd_nxt  = pop ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r + NW'(push) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/gtr_back.sv -----
`timescale 1ns / 1ps

module gtr_back
  import gtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  gtr_cell_t   q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] pixel_x,
  output logic [15:0] pixel_y,
  output logic [15:0] colour,
  output logic        last_pixel
);

  gtr_cell_t   cur_r, cur_nxt;
  logic        busy_r, busy_nxt;
  logic [2:0]  col_r, col_nxt;
  logic [2:0]  row_r, row_nxt;

  logic        ov_r, ov_nxt;
  logic [15:0] px_r, px_nxt;
  logic [15:0] py_r, py_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic        pl_r, pl_nxt;

  logic        adv, emit, row_last, col_last, at_end;
  logic [7:0]  col_bits;
  logic [15:0] pix_colour;

  always_comb begin
    adv      = !ov_r || out_ready;
    emit     = busy_r && adv;
    row_last = (({1'b0, row_r} + 4'd1) == cur_r.nrows);
    col_last = ((col_r + 3'd1) == cur_r.ncols);
    at_end   = row_last && col_last;
    q_pop    = q_valid && (!busy_r || (emit && at_end));

    case (col_r)
      3'd0:    col_bits = cur_r.glyph[0];
      3'd1:    col_bits = cur_r.glyph[1];
      3'd2:    col_bits = cur_r.glyph[2];
      3'd3:    col_bits = cur_r.glyph[3];
      3'd4:    col_bits = cur_r.glyph[4];
      default: col_bits = 8'h00;
    endcase
    if ((row_r == 3'd7) || (col_r == 3'd5)) begin
      pix_colour = cur_r.bg;
    end else begin
      pix_colour = col_bits[row_r] ? cur_r.fg : cur_r.bg;
    end

    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (q_pop) begin
      cur_nxt  = q_head;
      busy_nxt = 1'b1;
      col_nxt  = '0;
      row_nxt  = '0;
    end else if (emit && at_end) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      if (row_last) begin
        row_nxt = '0;
        col_nxt = col_r + 3'd1;
      end else begin
        row_nxt = row_r + 3'd1;
      end
    end

    ov_nxt = ov_r;
    px_nxt = px_r;
    py_nxt = py_r;
    pc_nxt = pc_r;
    pl_nxt = pl_r;
    if (adv) begin
      ov_nxt = busy_r;
      px_nxt = cur_r.x + 16'(col_r);
      py_nxt = cur_r.y + 16'(row_r);
      pc_nxt = pix_colour;
      pl_nxt = at_end;
    end

    out_valid  = ov_r;
    pixel_x    = px_r;
    pixel_y    = py_r;
    colour     = pc_r;
    last_pixel = pl_r;
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    col_r <= col_nxt;
    row_r <= row_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    pc_r  <= pc_nxt;
    pl_r  <= pl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_walk_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (({1'b0, row_r} < cur_r.nrows) && (col_r < cur_r.ncols)))
    else $error("pixel walk left the visible cell");

  a_cell_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((cur_r.ncols != 3'd0) && (cur_r.nrows != 4'd0)))
    else $error("empty cell reached the pixel walker");

  a_idle_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && at_end && !q_valid) |=> !busy_r)
    else $error("walker stayed busy after final pixel");

  a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && at_end) |=> (ov_r && pl_r))
    else $error("final pixel of a cell not flagged");
`endif

endmodule

// ----- hdl/glyph_text_rasterizer_top.sv -----
`timescale 1ns / 1ps
// A drawn character is written into the queue, loaded into the pixel walker and
// its first pixel registered at the output. The walker emits one pixel per cycle
// while out_tready is high, up to 48 per character; newlines and cells wholly off
// screen skip the queue. The 2-entry queue lets input run ahead of the walker.
// Reset (synchronous, rst_n low): cursor and line start to 0, width and height
// to 240, queue and output empty.

module glyph_text_rasterizer_top
  import gtr_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // char_code[7:0], start_x[23:8], start_y[39:24], fg_colour[55:40], bg_colour[71:56]
  input  logic [71:0] in_tdata,
  // new_string[0]
  input  logic        in_tuser,

  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_x[15:0], pixel_y[31:16], colour[47:32]
  output logic [47:0] out_tdata,
  output logic        out_tlast,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic        cfg_wr;

  logic        q_ready, q_push, q_valid, q_pop;
  gtr_cell_t   q_cell, q_head;

  logic [15:0] pixel_x, pixel_y, colour;

  always_comb begin
    cfg_pready = 1'b1;
    cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        GTR_REG_WIDTH:  width_nxt  = cfg_pwdata[15:0];
        GTR_REG_HEIGHT: height_nxt = cfg_pwdata[15:0];
        default:        width_nxt  = width_r;
      endcase
    end
    unique case (cfg_paddr[2])
      GTR_REG_WIDTH:  cfg_prdata = {16'h0000, width_r};
      GTR_REG_HEIGHT: cfg_prdata = {16'h0000, height_r};
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= GTR_WIDTH_RST;
      height_r <= GTR_HEIGHT_RST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  gtr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .char_code    (in_tdata[7:0]),
    .new_string   (in_tuser),
    .start_x      (in_tdata[23:8]),
    .start_y      (in_tdata[39:24]),
    .fg_colour    (in_tdata[55:40]),
    .bg_colour    (in_tdata[71:56]),
    .screen_width (width_r),
    .screen_height(height_r),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_cell       (q_cell)
  );

  gtr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cell(q_cell),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  gtr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .colour    (colour),
    .last_pixel(out_tlast)
  );

  assign out_tdata = {colour, pixel_y, pixel_x};

endmodule
